@@ design/rmslvl_pkg.sv @@
package rmslvl_pkg;

  // frame length limit and the widths that follow from it
  localparam int unsigned MAX_FRAME = 65536;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SQ_W      = 2 * SAMPLE_W - 1;
  localparam int unsigned SUM_W     = SQ_W - 1 + CNT_W;

  // square root operand and result
  localparam int unsigned ROOT_W    = SAMPLE_W;
  localparam int unsigned MEAN_W    = 2 * ROOT_W;

  // queue between the accumulator and the divide/root unit
  localparam int unsigned QUEUE_DEPTH = 2;

  // finished frame handed to the back end
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

endpackage

@@ design/rmslvl_front.sv @@
module rmslvl_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rmslvl_pkg::SAMPLE_W-1:0] sample,
  input  logic                               last,
  output logic                               push,
  output rmslvl_pkg::job_t                   push_job,
  input  logic                               q_full
);

  localparam int unsigned CNT_W = rmslvl_pkg::CNT_W;
  localparam int unsigned SUM_W = rmslvl_pkg::SUM_W;
  localparam int unsigned SQ_W  = rmslvl_pkg::SQ_W;

  logic                 accept;
  logic                 take;
  logic                 advance;
  logic signed [2*rmslvl_pkg::SAMPLE_W-1:0] prod;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_inc;
  logic                 ovf;
  logic                 s1_valid;
  logic [SQ_W-1:0]      s1_sq;
  logic                 s1_last;
  logic                 s1_ovf;
  logic [CNT_W-1:0]     s1_count;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_next;

  // transaction acceptance and frame length check
  assign in_stall  = s1_valid && s1_last && q_full;
  assign accept    = in_valid && !in_stall;
  assign take      = count < CNT_W'(rmslvl_pkg::MAX_FRAME);
  assign count_inc = take ? count + CNT_W'(1) : count;
  assign prod      = sample * sample;

  // sample count and overflow flag follow the accepted transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      count <= last ? '0 : count_inc;
      ovf   <= last ? 1'b0 : (ovf || !take);
    end
  end

  // squaring stage
  assign advance = s1_valid && !(s1_last && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq    <= take ? prod[SQ_W-1:0] : '0;
      s1_last  <= last;
      s1_ovf   <= ovf || !take;
      s1_count <= count_inc;
    end
  end

  // sum of squares, handed over on the last sample
  assign sum_next = sum + SUM_W'(s1_sq);
  assign push     = advance && s1_last;

  always_comb begin
    push_job       = '0;
    push_job.sum   = sum_next;
    push_job.count = s1_count;
    push_job.ovf   = s1_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (advance) begin
      sum <= s1_last ? '0 : sum_next;
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(rmslvl_pkg::MAX_FRAME))
    else $error("sample count beyond frame limit");
`endif

endmodule

@@ design/rmslvl_fifo.sv @@
module rmslvl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rmslvl_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output rmslvl_pkg::job_t pop_job,
  output logic             empty
);

  localparam int unsigned DEPTH = rmslvl_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  rmslvl_pkg::job_t  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = fill == FILL_W'(DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("frame pushed into a full queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

@@ design/rmslvl_back.sv @@
module rmslvl_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  rmslvl_pkg::job_t               pop_job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rmslvl_pkg::ROOT_W-1:0]  rms_level,
  output logic                           overflow
);

  localparam int unsigned CNT_W   = rmslvl_pkg::CNT_W;
  localparam int unsigned SUM_W   = rmslvl_pkg::SUM_W;
  localparam int unsigned ROOT_W  = rmslvl_pkg::ROOT_W;
  localparam int unsigned MEAN_W  = rmslvl_pkg::MEAN_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned DCNT_W  = $clog2(SUM_W);
  localparam int unsigned SCNT_W  = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [DCNT_W-1:0]  dcnt;
  logic [SCNT_W-1:0]  scnt;
  logic [CNT_W-1:0]   divisor;
  logic [CNT_W:0]     drem;
  logic [CNT_W:0]     drem_sh;
  logic               dge;
  logic [SUM_W-1:0]   quo;
  logic [SUM_W-1:0]   quo_next;
  logic [MEAN_W-1:0]  sq_op;
  logic [REM_W-1:0]   srem;
  logic [REM_W+1:0]   srem_sh;
  logic [REM_W+1:0]   trial;
  logic               sge;
  logic [REM_W+1:0]   srem_diff;
  logic [ROOT_W-1:0]  root;
  logic               job_ovf;
  logic               job_zero;
  logic               out_free;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  // restoring divider step, one quotient bit a cycle
  assign drem_sh  = {drem[CNT_W-1:0], quo[SUM_W-1]};
  assign dge      = drem_sh >= {1'b0, divisor};
  assign quo_next = {quo[SUM_W-2:0], dge};

  // square root step, two operand bits a cycle
  assign srem_sh   = {srem, sq_op[MEAN_W-1:MEAN_W-2]};
  assign trial     = (REM_W + 2)'({root, 2'b01});
  assign sge       = srem_sh >= trial;
  assign srem_diff = srem_sh - trial;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_DIV;
      ST_DIV:  if (dcnt == DCNT_W'(SUM_W - 1)) state_next = ST_SQRT;
      ST_SQRT: if (scnt == SCNT_W'(ROOT_W - 1)) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quo      <= pop_job.sum;
        divisor  <= pop_job.count;
        job_ovf  <= pop_job.ovf;
        job_zero <= pop_job.count == '0;
        drem     <= '0;
        dcnt     <= '0;
      end
      ST_DIV: begin
        drem  <= dge ? drem_sh - {1'b0, divisor} : drem_sh;
        quo   <= quo_next;
        dcnt  <= dcnt + DCNT_W'(1);
        sq_op <= MEAN_W'(quo_next);
        srem  <= '0;
        root  <= '0;
        scnt  <= '0;
      end
      ST_SQRT: begin
        sq_op <= {sq_op[MEAN_W-3:0], 2'b00};
        srem  <= sge ? srem_diff[REM_W-1:0] : srem_sh[REM_W-1:0];
        root  <= {root[ROOT_W-2:0], sge};
        scnt  <= scnt + SCNT_W'(1);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      rms_level <= job_zero ? '0 : root;
      overflow  <= job_ovf;
    end
  end

`ifndef SYNTHESIS
  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && state_next == ST_SQRT && !job_zero)
      |-> (quo_next >> MEAN_W) == '0)
    else $error("frame mean wider than root operand");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> root <= ROOT_W'(1 << (ROOT_W - 1)))
    else $error("root above full scale");
`endif

endmodule

@@ design/rms_level_of_frame_core.sv @@
// frame rms level meter: squares and sums samples at one transaction per cycle
// while in_stall is low; in_stall rises when a frame's last sample finds the queue full
// the mean comes from a bit-serial divider and the level from a bit-serial root
// the back end takes one frame at a time and a two-entry queue holds finished
// frames, so shorter frames may see stall
// synchronous active-high reset clears the accumulators, the queue and the output
module rms_level_of_frame_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rmslvl_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rmslvl_pkg::ROOT_W-1:0]         rms_level,
  output logic                                  overflow
);

  logic             push;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  rmslvl_pkg::job_t push_job;
  rmslvl_pkg::job_t pop_job;

  // accumulate squares and sample count per frame
  rmslvl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .last     (last),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // finished frames waiting for the divide and root
  rmslvl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // mean and square root, then the result register
  rmslvl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rms_level (rms_level),
    .overflow  (overflow)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import rmslvl_pkg::*;

  // idle cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT  = 4000;
  // settling time after the last expected result
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1700;
  localparam int NUM_PHASES   = 4;

  typedef enum int {FRAME_MIXED, FRAME_CONST, FRAME_QUIET} frame_style_t;

  typedef struct packed {
    logic [ROOT_W-1:0] level;
    logic              ovf;
  } frame_result_t;

  // running sum of squares per frame and the queue of frame levels still due
  class rms_scoreboard;
    logic [63:0]   square_sum;
    int unsigned   sample_count;
    bit            dropped;
    frame_result_t level_q[$];
    int            mismatches;

    function logic [16:0] floor_root(logic [63:0] v);
      logic [16:0] r;
      logic [16:0] t;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
        t = r | (17'd1 << b);
        if (64'(t) * 64'(t) <= v) r = t;
      end
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic l);
      longint v;
      logic [63:0] mean;
      frame_result_t res;
      v = s;
      if (sample_count < MAX_FRAME) begin
        square_sum   = square_sum + 64'(v * v);
        sample_count = sample_count + 1;
      end else begin
        dropped = 1'b1;
      end
      if (l) begin
        mean      = (sample_count == 0) ? 64'd0 : square_sum / 64'(sample_count);
        res.level = ROOT_W'(floor_root(mean));
        res.ovf   = dropped;
        level_q.push_back(res);
        square_sum   = '0;
        sample_count = 0;
        dropped      = 1'b0;
      end
    endfunction

    function void check_result(logic [ROOT_W-1:0] lvl, logic ovf);
      frame_result_t exp_res;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rms_level=%0d overflow=%0b", lvl, ovf);
        return;
      end
      exp_res = level_q.pop_front();
      if (lvl !== exp_res.level || ovf !== exp_res.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: rms_level exp %0d got %0d, overflow exp %0b got %0b",
                   exp_res.level, lvl, exp_res.ovf, ovf);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ROOT_W-1:0]          rms_level;
  logic                       overflow;

  rms_scoreboard level_board = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int recv_window = 0;
  bit recv_calm = 1'b0;
  int send_count = 0;
  bit send_calm = 1'b0;

  rms_level_of_frame_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rms_level (rms_level),
    .overflow  (overflow)
  );

  always #6 clk = ~clk;

  // receiver back-pressure, with calm windows of no stall
  always @(posedge clk) begin
    recv_window = recv_window + 1;
    if (recv_window % 64 == 0) recv_calm = ($urandom_range(3) == 0);
    out_stall <= !recv_calm && ($urandom_range(99) < stall_pct);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) level_board.note_sample(sample, last);
      if (out_valid && !out_stall) level_board.check_result(rms_level, overflow);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  // one sample transaction, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
    send_count++;
    if (send_count % 32 == 0) send_calm = ($urandom_range(3) == 0);
    while (!send_calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= l;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(frame_style_t style,
                                                            logic signed [SAMPLE_W-1:0] fill);
    logic signed [SAMPLE_W-1:0] s;
    case (style)
      FRAME_CONST: s = fill;
      FRAME_QUIET: s = SAMPLE_W'($signed($urandom_range(64)) - 32);
      default: begin
        case ($urandom_range(9))
          0: s = 16'sh8000;
          1: s = 16'sh7fff;
          2: s = '0;
          3: s = -16'sd1;
          default: s = SAMPLE_W'($urandom);
        endcase
      end
    endcase
    return s;
  endfunction

  // one frame: len samples, last mark on the final one
  task automatic send_frame(input int len, input frame_style_t style,
                            input logic signed [SAMPLE_W-1:0] fill);
    for (int k = 0; k < len; k++)
      send_sample(pick_sample(style, fill), k == len - 1);
  endtask

  initial begin
    int phase_items;
    int len;
    frame_style_t style;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: single-sample extremes and small hand-checked frames
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b1);
    send_frame(4, FRAME_CONST, 16'sh8000);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b1);

    // random frames, one idling mix per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 13) : $urandom_range(12, 1);
        case ($urandom_range(5))
          0: style = FRAME_CONST;
          1: style = FRAME_QUIET;
          default: style = FRAME_MIXED;
        endcase
        send_frame(len, style, SAMPLE_W'($urandom));
        phase_items += len;
      end
    end
    in_valid <= 1'b0;

    // drain outstanding frame levels, then watch for stray results
    while (level_board.level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (level_board.mismatches == 0 && level_board.level_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
